/* design/c_token_classifier_macros.svh */
// Assertion macros for the C token classifier.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef C_TOKEN_CLASSIFIER_MACROS_SVH
`define C_TOKEN_CLASSIFIER_MACROS_SVH

// Checked only while out of reset.
`define CTC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CTC_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/ctc_pkg.sv */
// Shared types, pattern tables and helper functions for the C token classifier.
// No dependencies; used by every module of the block.
package ctc_pkg;

    localparam int NUM_KEYWORDS     = 32;
    localparam int NUM_SYMBOLS      = 42;
    localparam int NUM_OPERATORS    = 33;
    localparam int KW_CHARS         = 8;
    localparam int SYM_CHARS        = 4;
    localparam int LENGTH_BITS_DEF  = 8;
    localparam int WORD_LENGTH_BITS = 8;
    localparam int WORD_LENGTH_MAX  = 255;

    localparam logic [7:0] CHAR_DQUOTE = 8'd34;
    localparam logic [7:0] CHAR_SQUOTE = 8'd39;
    localparam logic [7:0] CHAR_DOT    = 8'd46;
    localparam logic [7:0] CHAR_ZERO   = 8'd48;
    localparam logic [7:0] CHAR_NINE   = 8'd57;
    localparam logic [7:0] CHAR_SPACE  = 8'd32;
    localparam logic [7:0] CHAR_TAB    = 8'd9;
    localparam logic [7:0] CHAR_CR     = 8'd13;

    typedef enum logic [2:0] {
        WC_KEYWORD,
        WC_OPERATOR,
        WC_CONSTANT,
        WC_SPECIAL,
        WC_LITERAL,
        WC_IDENTIFIER
    } word_class_t;

    typedef struct packed {
        logic                     inside_word;
        logic [NUM_KEYWORDS-1:0]  keyword_candidates;
        logic [NUM_SYMBOLS-1:0]   symbol_candidates;
        logic                     all_digits_or_dots;
        logic [7:0]               first_char;
        logic [7:0]               latest_char;
    } word_state_t;

    typedef struct packed {
        logic [NUM_KEYWORDS-1:0]  keyword_candidates;
        logic [NUM_SYMBOLS-1:0]   symbol_candidates;
    } cand_next_t;

    localparam logic [KW_CHARS*8-1:0] KW_TABLE [NUM_KEYWORDS] = '{
        "auto", "double", "int", "struct", "break", "else", "long", "switch",
        "case", "enum", "register", "typedef", "char", "extern", "return", "union",
        "const", "float", "short", "unsigned", "continue", "for", "signed", "void",
        "default", "goto", "sizeof", "volatile", "do", "if", "static", "while"
    };

    localparam logic [SYM_CHARS*8-1:0] SYM_TABLE [NUM_SYMBOLS] = '{
        "+", ">", "~", "%=", "-", "<", "&", "<<=", "*", ">=", "^", ">>=",
        "/", "<=", "|", "&=", "%", "&&", "=", "^=", "++", "||", "+=", "|=",
        "--", "!", "-=", "==", "<<", "*=", "!=", ">>", "/=",
        "[", "]", "{", "}", ",", ";", ":", "(", ")"
    };

    function automatic int kw_len(input int idx);
        int n;
        n = 0;
        for (int b = 0; b < KW_CHARS; b++)
        begin
            if (KW_TABLE[idx][b*8 +: 8] != 8'd0)
                n++;
        end
        return n;
    endfunction

    function automatic logic [7:0] kw_char(input int idx, input int pos);
        return KW_TABLE[idx][(kw_len(idx)-1-pos)*8 +: 8];
    endfunction

    function automatic int sym_len(input int idx);
        int n;
        n = 0;
        for (int b = 0; b < SYM_CHARS; b++)
        begin
            if (SYM_TABLE[idx][b*8 +: 8] != 8'd0)
                n++;
        end
        return n;
    endfunction

    function automatic logic [7:0] sym_char(input int idx, input int pos);
        return SYM_TABLE[idx][(sym_len(idx)-1-pos)*8 +: 8];
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c inside {[CHAR_TAB:CHAR_CR]});
    endfunction

    function automatic logic is_digit_or_dot(input logic [7:0] c);
        return (c inside {[CHAR_ZERO:CHAR_NINE]}) || (c == CHAR_DOT);
    endfunction

endpackage

/* design/ctc_match.sv */
// Pattern matcher: narrows keyword and symbol candidate masks by one byte
// and classifies the pending word. Depends on ctc_pkg.
module ctc_match
    import ctc_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  word_state_t            state,
    input  logic [LENGTH_BITS-1:0] char_count,
    input  logic [7:0]             c,
    output cand_next_t             cand_next,
    output word_class_t            word_class
);

    logic [NUM_KEYWORDS-1:0] kw_hit;
    logic [NUM_KEYWORDS-1:0] kw_end;
    logic [NUM_SYMBOLS-1:0]  sym_hit;
    logic [NUM_SYMBOLS-1:0]  sym_end;
    logic                    is_kw;
    logic                    is_op;
    logic                    is_sp;
    logic                    is_lit;

    for (genvar i = 0; i < NUM_KEYWORDS; i++)
    begin : g_kw
        localparam int LEN = kw_len(i);
        logic hit;
        always_comb
        begin
            hit = 1'b0;
            for (int p = 0; p < LEN; p++)
            begin
                if (char_count == LENGTH_BITS'(p) && c == kw_char(i, p))
                    hit = 1'b1;
            end
        end
        assign kw_hit[i] = hit;
        assign kw_end[i] = (char_count == LENGTH_BITS'(LEN));
    end

    for (genvar i = 0; i < NUM_SYMBOLS; i++)
    begin : g_sym
        localparam int LEN = sym_len(i);
        logic hit;
        always_comb
        begin
            hit = 1'b0;
            for (int p = 0; p < LEN; p++)
            begin
                if (char_count == LENGTH_BITS'(p) && c == sym_char(i, p))
                    hit = 1'b1;
            end
        end
        assign sym_hit[i] = hit;
        assign sym_end[i] = (char_count == LENGTH_BITS'(LEN));
    end

    assign cand_next.keyword_candidates = state.keyword_candidates & kw_hit;
    assign cand_next.symbol_candidates  = state.symbol_candidates & sym_hit;

    assign is_kw  = |(state.keyword_candidates & kw_end);
    assign is_op  = |(state.symbol_candidates[NUM_OPERATORS-1:0]
                      & sym_end[NUM_OPERATORS-1:0]);
    assign is_sp  = |(state.symbol_candidates[NUM_SYMBOLS-1:NUM_OPERATORS]
                      & sym_end[NUM_SYMBOLS-1:NUM_OPERATORS]);
    assign is_lit = (state.first_char == CHAR_DQUOTE && state.latest_char == CHAR_DQUOTE)
                 || (state.first_char == CHAR_SQUOTE && state.latest_char == CHAR_SQUOTE);

    always_comb
    begin
        if (is_kw)
            word_class = WC_KEYWORD;
        else if (is_op)
            word_class = WC_OPERATOR;
        else if (state.all_digits_or_dots)
            word_class = WC_CONSTANT;
        else if (is_sp)
            word_class = WC_SPECIAL;
        else if (is_lit)
            word_class = WC_LITERAL;
        else
            word_class = WC_IDENTIFIER;
    end

endmodule

/* design/ctc_word_reg.sv */
// Pending-word state registers: candidate masks, saturating length,
// digit flag and first/latest characters. Depends on ctc_pkg.
module ctc_word_reg
    import ctc_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   take,
    input  logic                   clear,
    input  logic [7:0]             c,
    input  cand_next_t             cand_next,
    output word_state_t            state,
    output logic [LENGTH_BITS-1:0] char_count
);

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

    word_state_t            state_reg;
    word_state_t            state_next;
    logic [LENGTH_BITS-1:0] count_reg;
    logic [LENGTH_BITS-1:0] count_next;
    word_state_t            state_clear;

    always_comb
    begin
        state_clear                    = '0;
        state_clear.keyword_candidates = '1;
        state_clear.symbol_candidates  = '1;
        state_clear.all_digits_or_dots = 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        if (clear)
        begin
            state_next = state_clear;
            count_next = '0;
        end
        else if (take)
        begin
            state_next.inside_word        = 1'b1;
            if (!state_reg.inside_word)
                state_next.first_char     = c;
            state_next.latest_char        = c;
            state_next.all_digits_or_dots = state_reg.all_digits_or_dots & is_digit_or_dot(c);
            state_next.keyword_candidates = cand_next.keyword_candidates;
            state_next.symbol_candidates  = cand_next.symbol_candidates;
            if (count_reg != COUNT_MAX)
                count_next = count_reg + LENGTH_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= state_clear;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    assign state      = state_reg;
    assign char_count = count_reg;

endmodule

/* design/c_token_classifier.sv */
// C token classifier top level: input register, word state, matcher and result register.
// Depends on ctc_pkg, ctc_match, ctc_word_reg and c_token_classifier_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one item per cycle unless in_stall is high: text_byte and
//   end_of_text. A whitespace byte or end_of_text closes a pending word; other
//   bytes extend it. Whitespace or end_of_text with no pending word gives nothing.
//   Output channel (out_valid/out_stall) carries word_class and word_length,
//   at most one result per input item.
//   A closing item passes through the input register and then the result register.
//   Throughput: one item per cycle unless a result is held; the candidate masks narrow
//   in parallel for every byte, so the single pass through the matcher sets the rate.
//   While out_stall holds a result, the input register keeps one item and
//   in_stall rises only when that register is also full.
//   Reset clears the pending word, empties both registers and drops out_valid.
`include "c_token_classifier_macros.svh"

module c_token_classifier
    import ctc_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] word_class,
    output logic [7:0] word_length
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [7:0]             byte_reg;
    logic                   eot_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    word_class_t            class_reg;
    logic [7:0]             length_reg;
    logic                   advance;
    logic                   fire;
    logic                   sep;
    logic                   emit;
    logic                   take;
    logic                   clear;
    word_state_t            state;
    logic [LENGTH_BITS-1:0] char_count;
    cand_next_t             cand_next;
    word_class_t            class_now;
    logic [7:0]             length_now;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign fire     = in_valid_reg && advance;
    assign sep      = eot_reg || is_space(byte_reg);
    assign emit     = fire && sep && state.inside_word;
    assign take     = fire && !sep;
    assign clear    = fire && sep;

    assign in_valid_next  = in_stall ? in_valid_reg : in_valid;
    assign out_valid_next = advance ? emit : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= text_byte;
            eot_reg  <= end_of_text;
        end
        if (emit)
        begin
            class_reg  <= class_now;
            length_reg <= length_now;
        end
    end

    ctc_word_reg #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_word_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .clear      (clear),
        .c          (byte_reg),
        .cand_next  (cand_next),
        .state      (state),
        .char_count (char_count)
    );

    ctc_match #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_match (
        .state      (state),
        .char_count (char_count),
        .c          (byte_reg),
        .cand_next  (cand_next),
        .word_class (class_now)
    );

    if (LENGTH_BITS > WORD_LENGTH_BITS)
    begin : g_len_sat
        assign length_now = (char_count > LENGTH_BITS'(WORD_LENGTH_MAX))
                          ? WORD_LENGTH_BITS'(WORD_LENGTH_MAX)
                          : char_count[WORD_LENGTH_BITS-1:0];
    end
    else
    begin : g_len_ext
        assign length_now = WORD_LENGTH_BITS'(char_count);
    end

    assign out_valid   = out_valid_reg;
    assign word_class  = class_reg;
    assign word_length = length_reg;

    `CTC_ASSERT(a_stall_only_when_full, in_stall |-> (out_valid && out_stall), "input stalled while result side free")
    `CTC_ASSERT(a_length_nonzero, out_valid |-> (word_length != 8'd0), "result with zero word length")
    `CTC_ASSERT(a_keyword_length, (out_valid && word_class == WC_KEYWORD) |-> (word_length >= 8'd2 && word_length <= 8'd8), "keyword result with impossible length")
    `CTC_ASSERT_ALWAYS(a_reset_clears_output, !rst_n |=> !out_valid, "result present right after reset")

endmodule

/* verif/c_token_classifier_checker.sv */
// Checker for c_token_classifier: watches both channels, predicts each closed word's
// class and length, and compares it with the block's results.
// Depends on ctc_pkg for the word class enum, table sizes and character codes.
module c_token_classifier_checker
    import ctc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [2:0] word_class,
    input  logic [7:0] word_length,
    output int         mismatches,
    output int         words_outstanding
);

    typedef struct {
        word_class_t cls;
        logic [7:0]  len;
    } closed_word_t;

    string keyword_names [NUM_KEYWORDS] = '{
        "auto", "double", "int", "struct", "break", "else", "long", "switch",
        "case", "enum", "register", "typedef", "char", "extern", "return", "union",
        "const", "float", "short", "unsigned", "continue", "for", "signed", "void",
        "default", "goto", "sizeof", "volatile", "do", "if", "static", "while"
    };

    string symbol_names [NUM_SYMBOLS] = '{
        "+", ">", "~", "%=", "-", "<", "&", "<<=", "*", ">=", "^", ">>=",
        "/", "<=", "|", "&=", "%", "&&", "=", "^=", "++", "||", "+=", "|=",
        "--", "!", "-=", "==", "<<", "*=", "!=", ">>", "/=",
        "[", "]", "{", "}", ",", ";", ":", "(", ")"
    };

    closed_word_t closed_words [$];
    logic [7:0]   word_head [KW_CHARS];
    int unsigned  word_len;
    logic         in_word;
    logic         only_digits_dots;
    logic [7:0]   first_byte;
    logic [7:0]   last_byte;
    int           error_total;

    function automatic void clear_word();
        in_word          = 1'b0;
        word_len         = 0;
        only_digits_dots = 1'b1;
        first_byte       = 8'd0;
        last_byte        = 8'd0;
    endfunction

    function automatic logic spells(input string pat);
        if (pat.len() != word_len)
            return 1'b0;
        for (int k = 0; k < pat.len(); k++)
        begin
            if (word_head[k] != pat[k])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic word_class_t classify_word();
        logic is_op;
        logic is_sp;
        is_op = 1'b0;
        is_sp = 1'b0;
        foreach (keyword_names[i])
        begin
            if (spells(keyword_names[i]))
                return WC_KEYWORD;
        end
        foreach (symbol_names[i])
        begin
            if (spells(symbol_names[i]))
            begin
                if (i < NUM_OPERATORS)
                    is_op = 1'b1;
                else
                    is_sp = 1'b1;
            end
        end
        if (is_op)
            return WC_OPERATOR;
        if (only_digits_dots)
            return WC_CONSTANT;
        if (is_sp)
            return WC_SPECIAL;
        if (first_byte == last_byte && (first_byte == CHAR_DQUOTE || first_byte == CHAR_SQUOTE))
            return WC_LITERAL;
        return WC_IDENTIFIER;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        closed_word_t want;
        if (!rst_n)
        begin
            closed_words.delete();
            clear_word();
            error_total = 0;
            mismatches        <= 0;
            words_outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (closed_words.size() == 0)
                begin
                    error_total++;
                    if (error_total <= 10)
                        $display("unexpected result: class %0d length %0d",
                                 word_class, word_length);
                end
                else
                begin
                    want = closed_words.pop_front();
                    if (word_class !== want.cls || word_length !== want.len)
                    begin
                        error_total++;
                        if (error_total <= 10)
                            $display("mismatch: class exp %0d got %0d, length exp %0d got %0d",
                                     want.cls, word_class, want.len, word_length);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (end_of_text || text_byte == CHAR_SPACE ||
                    (text_byte >= CHAR_TAB && text_byte <= CHAR_CR))
                begin
                    if (in_word)
                    begin
                        want.cls = classify_word();
                        want.len = 8'(word_len);
                        closed_words.push_back(want);
                        clear_word();
                    end
                end
                else
                begin
                    if (!in_word)
                    begin
                        in_word    = 1'b1;
                        first_byte = text_byte;
                    end
                    last_byte = text_byte;
                    if (!((text_byte >= CHAR_ZERO && text_byte <= CHAR_NINE) ||
                          text_byte == CHAR_DOT))
                        only_digits_dots = 1'b0;
                    if (word_len < KW_CHARS)
                        word_head[word_len] = text_byte;
                    if (word_len < WORD_LENGTH_MAX)
                        word_len++;
                end
            end
            mismatches        <= error_total;
            words_outstanding <= closed_words.size();
        end
    end

endmodule

/* verif/c_token_classifier_test.sv */
// Testbench top for c_token_classifier: drives text bytes and end-of-text marks with
// random gaps and result stalls, and gives the verdict from the checker's count.
// Depends on ctc_pkg, c_token_classifier and c_token_classifier_checker.
module c_token_classifier_test;
    import ctc_pkg::*;

    localparam logic [7:0] CHAR_LF = 8'd10;
    localparam logic [7:0] CHAR_VT = 8'd11;
    localparam logic [7:0] CHAR_FF = 8'd12;
    localparam int ITEM_TARGET  = 1950;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [7:0] text_byte   = 8'd0;
    logic       end_of_text = 1'b0;
    logic       out_valid;
    logic       out_stall   = 1'b1;
    logic [2:0] word_class;
    logic [7:0] word_length;
    int         mismatches;
    int         words_outstanding;
    int         cycle_count = 0;
    int         items_sent  = 0;
    logic       tx_quiet    = 1'b0;
    logic       rx_quiet    = 1'b0;
    logic [7:0] word_text [$];

    c_token_classifier i_dut (.*);

    c_token_classifier_checker i_checker (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("c_token_classifier test failed");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] c, input logic eot);
        int gap;
        if ($urandom_range(47, 0) == 0)
            tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(13, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        text_byte   <= c;
        end_of_text <= eot;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_item(s[k], 1'b0);
    endtask

    function automatic void add_pattern(input logic [63:0] pat);
        for (int b = 7; b >= 0; b--)
        begin
            if (pat[b*8 +: 8] != 8'd0)
                word_text.push_back(pat[b*8 +: 8]);
        end
    endfunction

    initial
    begin : result_side
        int hold;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if ($urandom_range(40, 0) == 0)
                rx_quiet = !rx_quiet;
            hold = rx_quiet ? 0 : $urandom_range(13, 0);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin : stimulus
        int         kind;
        int         count;
        int         pick;
        int         long_words;
        logic [7:0] quote;
        long_words = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(CHAR_SPACE, 1'b0);
        send_text("if");
        send_item(CHAR_LF, 1'b0);
        send_text(">>=");
        send_item(CHAR_TAB, 1'b0);
        send_text("..");
        send_item(CHAR_VT, 1'b0);
        send_text("[");
        send_item(CHAR_FF, 1'b0);
        send_item(CHAR_SQUOTE, 1'b0);
        send_item(8'($urandom_range(255, 0)), 1'b1);
        send_item(8'd0, 1'b1);
        send_item(CHAR_DQUOTE, 1'b0);
        send_text("a");
        send_item(CHAR_DQUOTE, 1'b0);
        send_item(CHAR_CR, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h5A, 1'b1);

        while (items_sent < ITEM_TARGET)
        begin
            if (long_words < 2 && items_sent > 600 * (long_words + 1))
            begin
                count = $urandom_range(300, 250);
                pick  = $urandom_range(1, 0);
                repeat (count)
                    word_text.push_back(pick ? 8'($urandom_range(57, 48))
                                             : 8'($urandom_range(126, 33)));
                long_words++;
            end
            else
            begin
                kind = $urandom_range(99, 0);
                if (kind < 20)
                    add_pattern(KW_TABLE[$urandom_range(NUM_KEYWORDS - 1, 0)]);
                else if (kind < 35)
                    add_pattern(64'(SYM_TABLE[$urandom_range(NUM_SYMBOLS - 1, 0)]));
                else if (kind < 47)
                begin
                    repeat ($urandom_range(5, 1))
                        word_text.push_back($urandom_range(4, 0) == 0 ? CHAR_DOT
                                                                      : 8'($urandom_range(57, 48)));
                end
                else if (kind < 59)
                begin
                    quote = $urandom_range(1, 0) ? CHAR_DQUOTE : CHAR_SQUOTE;
                    word_text.push_back(quote);
                    repeat ($urandom_range(4, 0))
                        word_text.push_back(8'($urandom_range(126, 33)));
                    if ($urandom_range(4, 0) == 0)
                        quote = quote ^ (CHAR_DQUOTE ^ CHAR_SQUOTE);
                    word_text.push_back(quote);
                end
                else if (kind < 71)
                begin
                    word_text.push_back(8'($urandom_range(122, 97)));
                    repeat ($urandom_range(7, 0))
                        word_text.push_back($urandom_range(2, 0) == 0 ? 8'($urandom_range(57, 48))
                                                                      : 8'($urandom_range(122, 95)));
                end
                else if (kind < 81)
                begin
                    add_pattern(KW_TABLE[$urandom_range(NUM_KEYWORDS - 1, 0)]);
                    if ($urandom_range(1, 0) == 1 && word_text.size() > 1)
                        void'(word_text.pop_back());
                    else
                        word_text.push_back(8'($urandom_range(122, 97)));
                end
                else if (kind < 89)
                begin
                    add_pattern(64'(SYM_TABLE[$urandom_range(NUM_SYMBOLS - 1, 0)]));
                    add_pattern(64'(SYM_TABLE[$urandom_range(NUM_SYMBOLS - 1, 0)]));
                end
                else
                begin
                    repeat ($urandom_range(6, 1))
                        word_text.push_back(8'($urandom_range(255, 0)));
                end
            end
            while (word_text.size() > 0)
                send_item(word_text.pop_front(), 1'b0);
            repeat ($urandom_range(3, 0) == 0 ? $urandom_range(3, 2) : 1)
            begin
                pick = $urandom_range(6, 0);
                if (pick == 6)
                    send_item(8'($urandom_range(255, 0)), 1'b1);
                else
                    send_item(pick == 5 ? CHAR_SPACE : CHAR_TAB + 8'(pick), 1'b0);
            end
        end
        send_item(8'($urandom_range(255, 0)), 1'b1);
        in_valid <= 1'b0;

        @(posedge clk);
        while (words_outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("c_token_classifier test passed");
        else
            $display("c_token_classifier test failed");
        $finish;
    end

endmodule
